@@ rtl/core/assert_macros.svh @@
// Assertion macros used by the checker module of the decoder.
// Depends on nothing; each macro takes a label, a clock, an active-low reset and two expressions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ rtl/core/rlebd_pkg.sv @@
// Package of the byte-run decoder: constants and the command and status types.
// Depends on nothing; used by the controller, the datapath and the core of the decoder.
`default_nettype none

package rlebd_pkg;

  localparam int LengthBitsDef = 24;
  localparam int MaxPerStep = 64;
  localparam logic [7:0] LiteralMaxCode = 8'd127;
  localparam logic [7:0] RunBias = 8'd127;

  typedef struct packed {
    logic accept;
    logic emit;
    logic cfg_write;
  } cmd_t;

  typedef struct packed {
    logic run_phase;
    logic chunk_last;
    logic slot_free;
  } sts_t;

endpackage

`default_nettype wire

@@ rtl/core/rlebd_ctrl.sv @@
// Controller of the byte-run decoder: chooses between taking input and emitting run copies.
// Depends on rlebd_pkg for the command and status types.
`default_nettype none

module rlebd_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  input  wire logic           cfg_wr_en,
  input  wire rlebd_pkg::sts_t sts,
  output rlebd_pkg::cmd_t     cmd,
  output logic                in_ready
);

  typedef enum logic [0:0] {
    S_IDLE,
    S_EMIT
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    in_ready      = (state_r == S_IDLE) && sts.slot_free && !cfg_wr_en;
    cmd.accept    = in_ready && in_valid && !cfg_wr_en;
    cmd.emit      = (state_r == S_EMIT) && sts.slot_free && !cfg_wr_en;
    cmd.cfg_write = cfg_wr_en;
    state_nxt     = state_r;
    case (state_r)
      S_IDLE: begin
        if (cmd.accept && sts.run_phase) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (cmd.emit && sts.chunk_last) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    if (cfg_wr_en) begin
      state_nxt = S_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/rlebd_dp.sv @@
// Datapath of the byte-run decoder: code parsing, counters, run value and output register.
// Depends on rlebd_pkg for constants and the command and status types.
`default_nettype none

module rlebd_dp #(
  parameter int LENGTH_BITS = rlebd_pkg::LengthBitsDef
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire rlebd_pkg::cmd_t        cmd,
  output rlebd_pkg::sts_t             sts,
  input  wire logic [LENGTH_BITS-1:0] cfg_wr_data,
  input  wire logic [7:0]             in_byte,
  input  wire logic                   out_ready,
  output logic                        out_valid,
  output logic [7:0]                  out_byte,
  output logic                        out_last_of_input,
  output logic                        out_image_done
);

  localparam int ChunkBits = $clog2(rlebd_pkg::MaxPerStep + 1);

  typedef enum logic [1:0] {
    PH_CODE,
    PH_LITERAL,
    PH_RUNVAL,
    PH_CARRY
  } phase_t;

  phase_t                 phase_r, phase_nxt;
  logic [7:0]             pending_r, pending_nxt;
  logic [LENGTH_BITS-1:0] bytes_left_r, bytes_left_nxt;
  logic [7:0]             held_r, held_nxt;
  logic [7:0]             saved_r, saved_nxt;
  logic [ChunkBits-1:0]   chunk_r, chunk_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [7:0]             out_byte_r, out_byte_nxt;
  logic                   out_last_r, out_last_nxt;
  logic                   out_done_r, out_done_nxt;

  logic [7:0]             code;
  logic [7:0]             tc_raw;
  logic [LENGTH_BITS-1:0] tc_len;
  logic [LENGTH_BITS-1:0] tc_clamp;
  phase_t                 tc_phase;
  logic [ChunkBits-1:0]   chunk_load;
  logic                   take_code;

  always_comb begin
    code = (phase_r == PH_CARRY) ? saved_r : in_byte;
    if (code <= rlebd_pkg::LiteralMaxCode) begin
      tc_raw   = code + 8'd1;
      tc_phase = PH_LITERAL;
    end else begin
      tc_raw   = code - rlebd_pkg::RunBias;
      tc_phase = PH_RUNVAL;
    end
    tc_len   = LENGTH_BITS'(tc_raw);
    tc_clamp = (tc_len > bytes_left_r) ? bytes_left_r : tc_len;
    if (pending_r > 8'(rlebd_pkg::MaxPerStep)) begin
      chunk_load = ChunkBits'(rlebd_pkg::MaxPerStep);
    end else begin
      chunk_load = ChunkBits'(pending_r);
    end
  end

  always_comb begin
    phase_nxt      = phase_r;
    pending_nxt    = pending_r;
    bytes_left_nxt = bytes_left_r;
    held_nxt       = held_r;
    saved_nxt      = saved_r;
    chunk_nxt      = chunk_r;
    out_byte_nxt   = out_byte_r;
    out_last_nxt   = out_last_r;
    out_done_nxt   = out_done_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    take_code      = 1'b0;
    if (cmd.cfg_write) begin
      bytes_left_nxt = cfg_wr_data;
      phase_nxt      = PH_CODE;
      pending_nxt    = 8'd0;
      held_nxt       = 8'd0;
    end else if (cmd.accept) begin
      case (phase_r)
        PH_LITERAL: begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = in_byte;
          out_last_nxt  = 1'b1;
          out_done_nxt  = (pending_r == 8'd1) && (bytes_left_r == '0);
          pending_nxt   = pending_r - 8'd1;
          if (pending_r == 8'd1) begin
            phase_nxt = PH_CODE;
          end
        end
        PH_RUNVAL: begin
          held_nxt  = in_byte;
          chunk_nxt = chunk_load;
        end
        PH_CARRY: begin
          saved_nxt = in_byte;
          chunk_nxt = chunk_load;
        end
        PH_CODE: take_code = 1'b1;
        default: phase_nxt = PH_CODE;
      endcase
    end else if (cmd.emit) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = held_r;
      out_last_nxt  = sts.chunk_last;
      out_done_nxt  = sts.chunk_last && (pending_r == 8'd1) && (bytes_left_r == '0);
      pending_nxt   = pending_r - 8'd1;
      chunk_nxt     = chunk_r - ChunkBits'(1);
      if (sts.chunk_last) begin
        if (pending_r == 8'd1) begin
          phase_nxt = PH_CODE;
          take_code = (phase_r == PH_CARRY);
        end else begin
          phase_nxt = PH_CARRY;
        end
      end
    end
    if (take_code && (bytes_left_r != '0)) begin
      bytes_left_nxt = bytes_left_r - tc_clamp;
      pending_nxt    = tc_clamp[7:0];
      phase_nxt      = tc_phase;
    end
  end

  always_comb begin
    sts.run_phase     = (phase_r == PH_RUNVAL) || (phase_r == PH_CARRY);
    sts.chunk_last    = (chunk_r == ChunkBits'(1));
    sts.slot_free     = !out_valid_r || out_ready;
    out_valid         = out_valid_r;
    out_byte          = out_byte_r;
    out_last_of_input = out_last_r;
    out_image_done    = out_done_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_CODE;
      pending_r    <= 8'd0;
      bytes_left_r <= '0;
      chunk_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      pending_r    <= pending_nxt;
      bytes_left_r <= bytes_left_nxt;
      chunk_r      <= chunk_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    held_r     <= held_nxt;
    saved_r    <= saved_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
    out_done_r <= out_done_nxt;
  end

endmodule

`default_nettype wire

@@ rtl/core/rle_byte_run_decoder_core.sv @@
// Byte-run decoder core. A code byte is taken and gives no output; a literal byte appears
// at the output register in the cycle after its transaction, one byte per cycle while the
// output is not stalled. A run value byte holds the input while its copies go out, at most
// 64 per accepted byte, the first after the emit state and the run copy counter are loaded.
// Synchronous active-low reset clears the counters, the length and the output valid flag.
`default_nettype none

module rle_byte_run_decoder_core #(
  parameter int LENGTH_BITS = rlebd_pkg::LengthBitsDef
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cfg_wr_en,
  input  wire logic [LENGTH_BITS-1:0] cfg_wr_data,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [7:0]             in_byte,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [7:0]                  out_byte,
  output logic                        out_last_of_input,
  output logic                        out_image_done
);

  rlebd_pkg::cmd_t cmd;
  rlebd_pkg::sts_t sts;

  rlebd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .cfg_wr_en (cfg_wr_en),
    .sts       (sts),
    .cmd       (cmd),
    .in_ready  (in_ready)
  );

  rlebd_dp #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .cfg_wr_data       (cfg_wr_data),
    .in_byte           (in_byte),
    .out_ready         (out_ready),
    .out_valid         (out_valid),
    .out_byte          (out_byte),
    .out_last_of_input (out_last_of_input),
    .out_image_done    (out_image_done)
  );

endmodule

`default_nettype wire

@@ rtl/core/rlebd_checker.sv @@
// Port-level checker of the byte-run decoder, bound to the top level.
// Depends on assert_macros.svh for the assertion macros.
`default_nettype none
`include "assert_macros.svh"

module rlebd_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_byte,
  input wire logic       out_last_of_input,
  input wire logic       out_image_done
);

  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_byte))
  `ASSERT_IMPLY(a_done_is_last, clk, rst_n, out_valid && out_image_done, out_last_of_input)
  `ASSERT_IMPLY(a_ready_slot, clk, rst_n, in_ready, !out_valid || out_ready)

endmodule

bind rle_byte_run_decoder_core rlebd_checker u_rlebd_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_byte          (out_byte),
  .out_last_of_input (out_last_of_input),
  .out_image_done    (out_image_done)
);

`default_nettype wire
